@@ rtl/core/jcs_pkg.sv @@
// shared types and character codes for the json comment stripper
package jcs_pkg;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // default depth of the step queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2
    } t_mode;

    // one step of work: held byte examined against its lookahead, and on the
    // final byte of a text that byte examined against a zero lookahead
    typedef struct packed {
        logic [7:0] a_char;
        logic       a_valid;
        logic [7:0] b_char;
        logic       last;
    } t_step;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
    } t_item;

endpackage

@@ rtl/core/jcs_front.sv @@
// front end: holds one byte back and forms lookahead steps
module jcs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  logic           i_q_full,
    output logic           o_push,
    output jcs_pkg::t_step o_step
);

    logic [7:0] r_held_char, n_held_char;
    logic       r_held_valid, n_held_valid;
    logic       w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        o_step.a_char  = r_held_char;
        o_step.a_valid = r_held_valid;
        o_step.b_char  = i_char;
        o_step.last    = i_last;
        // the very first byte of a text yields no work unless it is also its last
        o_push = w_accept && (r_held_valid || i_last);
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        if (w_accept) begin
            n_held_char  = i_last ? jcs_pkg::CH_NUL : i_char;
            n_held_valid = !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_char  <= jcs_pkg::CH_NUL;
            r_held_valid <= 1'b0;
        end else begin
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
        end
    end

`ifndef SYNTHESIS
    a_held_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_last |=> !r_held_valid)
        else $error("held byte survives end of text");
`endif

endmodule

@@ rtl/core/jcs_queue.sv @@
// small step queue between front and back
module jcs_queue #(
    parameter int DEPTH = jcs_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jcs_pkg::t_step i_data,
    output logic           o_full,
    input  logic           i_pop,
    output jcs_pkg::t_step o_data,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jcs_pkg::t_step r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(w_push) - CW'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("step queue count beyond depth");
`endif

endmodule

@@ rtl/core/jcs_back.sv @@
// back end: comment and string tracking, result buffering
module jcs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jcs_pkg::t_step i_step,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output jcs_pkg::t_item o_item
);

    typedef struct packed {
        jcs_pkg::t_mode mode;
        logic           inq;
        logic           skip;
        logic [7:0]     p1;
        logic [7:0]     p2;
        logic [1:0]     seen;
    } t_cstate;

    typedef struct packed {
        t_cstate st;
        logic    keep;
    } t_exam;

    localparam t_cstate CSTATE_RESET = '{
        mode: jcs_pkg::MODE_NONE, inq: 1'b0, skip: 1'b0,
        p1: jcs_pkg::CH_NUL, p2: jcs_pkg::CH_NUL, seen: 2'd0};

    function automatic t_exam examine(t_cstate s, logic [7:0] c, logic [7:0] n);
        t_exam r;
        r.st   = s;
        r.keep = 1'b0;
        if (s.skip) begin
            r.st.skip = 1'b0;
        end else begin
            // quote toggles outside comments unless escaped by a lone backslash
            if (s.mode != jcs_pkg::MODE_LINE && s.mode != jcs_pkg::MODE_BLOCK &&
                c == jcs_pkg::CH_QUOTE &&
                (s.seen < 2'd2 || s.p1 != jcs_pkg::CH_BACKSLASH ||
                 s.p2 == jcs_pkg::CH_BACKSLASH)) begin
                r.st.inq = !s.inq;
            end
            if (r.st.inq) begin
                r.keep = 1'b1;
            end else begin
                unique case (s.mode)
                    jcs_pkg::MODE_LINE: begin
                        if (c == jcs_pkg::CH_NEWLINE) begin
                            r.st.mode = jcs_pkg::MODE_NONE;
                            r.keep    = 1'b1;
                        end
                    end
                    jcs_pkg::MODE_BLOCK: begin
                        if (c == jcs_pkg::CH_STAR && n == jcs_pkg::CH_SLASH) begin
                            r.st.mode = jcs_pkg::MODE_NONE;
                            r.st.skip = 1'b1;
                        end
                    end
                    default: begin
                        if (c == jcs_pkg::CH_SLASH && n == jcs_pkg::CH_SLASH) begin
                            r.st.mode = jcs_pkg::MODE_LINE;
                            r.st.skip = 1'b1;
                        end else if (c == jcs_pkg::CH_SLASH && n == jcs_pkg::CH_STAR) begin
                            r.st.mode = jcs_pkg::MODE_BLOCK;
                            r.st.skip = 1'b1;
                        end else begin
                            r.keep = 1'b1;
                        end
                    end
                endcase
            end
        end
        r.st.p2 = s.p1;
        r.st.p1 = c;
        if (s.seen < 2'd2) begin
            r.st.seen = s.seen + 2'd1;
        end
        return r;
    endfunction

    t_cstate        r_st, n_st;
    jcs_pkg::t_item r_slot0, n_slot0, r_slot1, n_slot1;
    logic [1:0]     r_cnt, n_cnt;
    t_exam          w_ea, w_eb;
    t_cstate        w_st_mid;
    logic           w_keep_a, w_keep_b, w_hs;
    jcs_pkg::t_item w_item_a, w_item_b, w_item_none;

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot0;
    assign w_hs    = o_valid && i_ready;
    // take a new step once the buffer is empty after this cycle's hand-off
    assign o_pop   = !i_q_empty && ((r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready));

    always_comb begin
        w_ea     = examine(r_st, i_step.a_char, i_step.b_char);
        w_st_mid = i_step.a_valid ? w_ea.st : r_st;
        w_eb     = examine(w_st_mid, i_step.b_char, jcs_pkg::CH_NUL);
        w_keep_a = i_step.a_valid && w_ea.keep;
        w_keep_b = i_step.last && w_eb.keep;

        w_item_a    = '{ch: i_step.a_char, has: 1'b1, last: i_step.last && !w_keep_b};
        w_item_b    = '{ch: i_step.b_char, has: 1'b1, last: 1'b1};
        w_item_none = '{ch: jcs_pkg::CH_NUL, has: 1'b0, last: 1'b1};

        n_st    = r_st;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt;

        if (w_hs) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end

        if (o_pop) begin
            n_st = i_step.last ? CSTATE_RESET : w_st_mid;
            priority if (w_keep_a && w_keep_b) begin
                n_slot0 = w_item_a;
                n_slot1 = w_item_b;
                n_cnt   = 2'd2;
            end else if (w_keep_a) begin
                n_slot0 = w_item_a;
                n_cnt   = 2'd1;
            end else if (w_keep_b) begin
                n_slot0 = w_item_b;
                n_cnt   = 2'd1;
            end else if (i_step.last) begin
                n_slot0 = w_item_none;
                n_cnt   = 2'd1;
            end else begin
                n_cnt   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= CSTATE_RESET;
            r_cnt <= 2'd0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overfilled");
    a_last_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_step.last |=> o_valid)
        else $error("end of text produced no item");
    a_last_resets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_step.last |=> (r_st.mode == jcs_pkg::MODE_NONE && !r_st.inq &&
                                  !r_st.skip && r_st.seen == 2'd0))
        else $error("tracking state not cleared after end of text");
    a_two_items_end_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> r_slot1.last && !r_slot0.last)
        else $error("two buffered items outside end of text");
`endif

endmodule

@@ rtl/core/json_comment_stripper.sv @@
// top level of the json comment stripper: front, step queue and back
//
//  channel   dir  handshake               item contents
//  --------  ---  ----------------------  ----------------------------------------------
//  s (in)    in   i_s_tvalid/o_s_tready   tdata[7:0] raw byte, tlast end of text
//  m (out)   out  o_m_tvalid/i_m_tready   tdata[7:0] kept byte, tuser[0] has byte, tlast
//
// one input item per cycle while the queue is not full; the front holds one byte back for
// lookahead and writes one step into the queue per byte after the first of a text (one step
// for a one-byte text); the back registers the items of each step it takes
// a final byte can yield two output items, so that step holds the output for both; all
// other steps yield at most one item
// a kept byte is offered only after the byte behind it is taken, via the queue and the result buffer;
// a final byte needs no next byte, its lookahead being a zero byte
// reset is synchronous and active low; no clearing pass is needed
module json_comment_stripper #(
    parameter int QUEUE_DEPTH = jcs_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_char
    input  logic       i_s_tlast,   // in_last
    // output byte stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic       o_m_tuser,   // [0] has_char
    output logic       o_m_tlast    // out_last
);

    jcs_pkg::t_step w_push_step, w_pop_step;
    jcs_pkg::t_item w_item;
    logic           w_push, w_pop, w_q_full, w_q_empty;

    // lookahead pairing and step generation
    jcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_char   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_step   (w_push_step)
    );

    // decouples input acceptance from output stalls
    jcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_step),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_step),
        .o_empty (w_q_empty)
    );

    // comment and string tracking, output buffering
    jcs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_pop_step),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_item    (w_item)
    );

    assign o_m_tdata = w_item.ch;
    assign o_m_tuser = w_item.has;
    assign o_m_tlast = w_item.last;

endmodule

@@ verif/json_comment_stripper_tb.sv @@
// self-checking testbench for the json comment stripper: directed table, random texts
`timescale 1ns / 1ps

module json_comment_stripper_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_TAIL   = 150;   // last input items sent with no idling
    localparam int BACKLOG_AT   = 300;   // output count at which the long hold starts
    localparam int BACKLOG_HOLD = 80;    // cycles of the long output hold
    localparam int SETTLE       = 12;    // pipeline plus lookahead, with margin
    localparam int STALL_LIMIT  = 1000;  // cycles with no item moving on either side
    localparam int PRINT_LIMIT  = 40;

    // one input item plus an optional hand-written expectation
    typedef struct packed {
        logic [7:0]     ch;
        logic           last;
        logic           typed;
        logic [1:0]     n_exp;
        jcs_pkg::t_item e0;
        jcs_pkg::t_item e1;
    } t_row;

    localparam jcs_pkg::t_item NO_ITEM = '0;

    // directed texts; rows marked typed carry their own expected items
    localparam t_row DIRECTED [26] = '{
        // one-byte texts: lowest and highest byte pass straight through
        '{8'h00, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1}, NO_ITEM},
        '{8'hFF, 1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b1}, NO_ITEM},
        // text that is only a line opener: nothing kept, one empty end item
        '{jcs_pkg::CH_SLASH, 1'b0, 1'b1, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_SLASH, 1'b1, 1'b1, 2'd1, '{jcs_pkg::CH_NUL, 1'b0, 1'b1}, NO_ITEM},
        // quote right after a leading backslash is not escaped, opens a string
        '{jcs_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_QUOTE,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_QUOTE,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        // block comment holding a quote
        '{jcs_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_STAR,      1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_QUOTE,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_STAR,      1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        // empty line comment, its newline survives
        '{jcs_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_NEWLINE,   1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        // string with an escaped quote, then a double backslash before the close
        '{jcs_pkg::CH_QUOTE,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_QUOTE,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_QUOTE,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        // stray closer: its star is plain text, its slash opens a line comment with the next slash
        '{jcs_pkg::CH_STAR,      1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        // a star and a final byte inside that line comment, left open at the end of the text
        '{jcs_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{jcs_pkg::CH_STAR,      1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM},
        '{8'h71,                 1'b1, 1'b0, 2'd0, NO_ITEM, NO_ITEM}
    };

    // dut ports
    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] in_char
    logic       i_s_tlast  = 1'b0;    // in_last
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [7:0] out_char
    logic       o_m_tuser;            // [0] has_char
    logic       o_m_tlast;            // out_last

    // stimulus and expected output
    t_row           stim_q [$];
    jcs_pkg::t_item stripped_q [$];
    string plain_chars = "{}[]:,.-+ 0123456789abcdeflnrstu\t\r";

    // predictor state
    logic [7:0]     pr_held;
    logic           pr_held_ok;
    jcs_pkg::t_mode pr_mode;
    logic           pr_quoted;
    logic           pr_skip;
    logic [7:0]     pr_prev1;
    logic [7:0]     pr_prev2;
    logic [1:0]     pr_seen;

    // bookkeeping
    logic           src_on = 1'b0;
    int             src_gap = 0;
    int             hold_left = 0;
    logic           backlog_done = 1'b0;
    int             n_items_out = 0;
    int             mismatch_count = 0;
    int             idle_cycles = 0;
    t_row           sent_row;
    jcs_pkg::t_item pred0, pred1;
    int             n_pred;
    jcs_pkg::t_item got_item, want_item;

    json_comment_stripper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void clear_strip_state();
        pr_held    = 8'h00;
        pr_held_ok = 1'b0;
        pr_mode    = jcs_pkg::MODE_NONE;
        pr_quoted  = 1'b0;
        pr_skip    = 1'b0;
        pr_prev1   = 8'h00;
        pr_prev2   = 8'h00;
        pr_seen    = 2'd0;
    endfunction

    // decide whether byte c survives, given the byte after it
    function automatic logic byte_survives(input logic [7:0] c, input logic [7:0] ahead);
        logic keep;
        if (pr_skip) begin
            // second half of a delimiter
            pr_skip = 1'b0;
            keep = 1'b0;
        end else begin
            // quotes only count outside comments, and not when escaped
            if (pr_mode != jcs_pkg::MODE_LINE && pr_mode != jcs_pkg::MODE_BLOCK &&
                c == jcs_pkg::CH_QUOTE &&
                (pr_seen < 2'd2 || pr_prev1 != jcs_pkg::CH_BACKSLASH ||
                 pr_prev2 == jcs_pkg::CH_BACKSLASH))
                pr_quoted = ~pr_quoted;

            if (pr_quoted) begin
                keep = 1'b1;
            end else if (pr_mode == jcs_pkg::MODE_LINE) begin
                keep = (c == jcs_pkg::CH_NEWLINE);
                if (keep)
                    pr_mode = jcs_pkg::MODE_NONE;
            end else if (pr_mode == jcs_pkg::MODE_BLOCK) begin
                if (c == jcs_pkg::CH_STAR && ahead == jcs_pkg::CH_SLASH) begin
                    pr_mode = jcs_pkg::MODE_NONE;
                    pr_skip = 1'b1;
                end
                keep = 1'b0;
            end else if (c == jcs_pkg::CH_SLASH && ahead == jcs_pkg::CH_SLASH) begin
                pr_mode = jcs_pkg::MODE_LINE;
                pr_skip = 1'b1;
                keep = 1'b0;
            end else if (c == jcs_pkg::CH_SLASH && ahead == jcs_pkg::CH_STAR) begin
                pr_mode = jcs_pkg::MODE_BLOCK;
                pr_skip = 1'b1;
                keep = 1'b0;
            end else begin
                keep = 1'b1;
            end
        end
        pr_prev2 = pr_prev1;
        pr_prev1 = c;
        if (pr_seen < 2'd2)
            pr_seen = pr_seen + 2'd1;
        return keep;
    endfunction

    // output items caused by one input byte
    function automatic void strip_step(input logic [7:0] ch, input logic last,
                                       output jcs_pkg::t_item r0,
                                       output jcs_pkg::t_item r1, output int n);
        jcs_pkg::t_item kept;
        r0 = NO_ITEM;
        r1 = NO_ITEM;
        n  = 0;
        if (pr_held_ok) begin
            if (byte_survives(pr_held, ch)) begin
                r0 = '{pr_held, 1'b1, 1'b0};
                n  = 1;
            end
        end
        if (last) begin
            // final byte looks ahead at a zero byte
            if (byte_survives(ch, jcs_pkg::CH_NUL)) begin
                kept = '{ch, 1'b1, 1'b0};
                if (n == 0)
                    r0 = kept;
                else
                    r1 = kept;
                n++;
            end
            if (n == 0) begin
                r0 = '{jcs_pkg::CH_NUL, 1'b0, 1'b0};
                n  = 1;
            end
            if (n == 1)
                r0.last = 1'b1;
            else
                r1.last = 1'b1;
            clear_strip_state();
        end else begin
            pr_held    = ch;
            pr_held_ok = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick_text_byte(input logic no_quote);
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0:       c = 8'($urandom_range(0, 255));
            1:       c = jcs_pkg::CH_SLASH;
            2:       c = jcs_pkg::CH_STAR;
            3:       c = jcs_pkg::CH_QUOTE;
            4:       c = jcs_pkg::CH_BACKSLASH;
            5:       c = jcs_pkg::CH_NEWLINE;
            default: c = 8'(plain_chars[$urandom_range(0, plain_chars.len() - 1)]);
        endcase
        if (no_quote && c == jcs_pkg::CH_QUOTE)
            c = 8'(plain_chars[0]);
        return c;
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        stim_q.push_back('{c, 1'b0, 1'b0, 2'd0, NO_ITEM, NO_ITEM});
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch %s: got %0h expected %0h (output item %0d, t=%0t)",
                     what, got, want, n_items_out, $time);
        mismatch_count++;
    endtask

    // stimulus build, reset and end of run
    initial begin
        int n_tok;
        clear_strip_state();
        foreach (DIRECTED[i])
            stim_q.push_back(DIRECTED[i]);

        // random texts: mostly well-formed strings and comments around plain text
        while (stim_q.size() < $size(DIRECTED) + RANDOM_ITEMS) begin
            n_tok = $urandom_range(1, 12);
            repeat (n_tok) begin
                case ($urandom_range(0, 11))
                    0: add_byte(8'($urandom_range(0, 255)));
                    1: begin
                        // string, now and then left open
                        add_byte(jcs_pkg::CH_QUOTE);
                        repeat ($urandom_range(0, 8)) begin
                            if ($urandom_range(0, 5) == 0) begin
                                add_byte(jcs_pkg::CH_BACKSLASH);
                                add_byte($urandom_range(0, 1) ? jcs_pkg::CH_QUOTE
                                                              : jcs_pkg::CH_BACKSLASH);
                            end else begin
                                add_byte(pick_text_byte(1'b1));
                            end
                        end
                        if ($urandom_range(0, 7) != 0)
                            add_byte(jcs_pkg::CH_QUOTE);
                    end
                    2: begin
                        add_byte(jcs_pkg::CH_SLASH);
                        add_byte(jcs_pkg::CH_SLASH);
                        repeat ($urandom_range(0, 8)) add_byte(pick_text_byte(1'b0));
                        if ($urandom_range(0, 5) != 0)
                            add_byte(jcs_pkg::CH_NEWLINE);
                    end
                    3: begin
                        add_byte(jcs_pkg::CH_SLASH);
                        add_byte(jcs_pkg::CH_STAR);
                        repeat ($urandom_range(0, 8)) add_byte(pick_text_byte(1'b0));
                        if ($urandom_range(0, 5) != 0) begin
                            add_byte(jcs_pkg::CH_STAR);
                            add_byte(jcs_pkg::CH_SLASH);
                        end
                    end
                    4: begin
                        add_byte(jcs_pkg::CH_STAR);
                        add_byte(jcs_pkg::CH_SLASH);
                    end
                    5: begin
                        add_byte(jcs_pkg::CH_BACKSLASH);
                        add_byte(jcs_pkg::CH_QUOTE);
                    end
                    6: begin
                        add_byte(jcs_pkg::CH_BACKSLASH);
                        add_byte(jcs_pkg::CH_BACKSLASH);
                        add_byte(jcs_pkg::CH_QUOTE);
                    end
                    default: add_byte(pick_text_byte(1'b0));
                endcase
            end
            stim_q[stim_q.size() - 1].last = 1'b1;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_on  <= 1'b1;

        // everything sent and every expected item seen, then let the pipe drain
        while (stim_q.size() != 0 || stripped_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // sender: predicts on every accepted item, idles in short random bursts
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            sent_row = stim_q.pop_front();
            strip_step(sent_row.ch, sent_row.last, pred0, pred1, n_pred);
            if (sent_row.typed) begin
                n_pred = sent_row.n_exp;
                pred0  = sent_row.e0;
                pred1  = sent_row.e1;
            end
            if (n_pred > 0)
                stripped_q.push_back(pred0);
            if (n_pred > 1)
                stripped_q.push_back(pred1);
            if (stim_q.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
                src_gap = $urandom_range(1, 5);
            if (src_gap == 0 && stim_q.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= stim_q[0].ch;
                i_s_tlast  <= stim_q[0].last;
            end else begin
                i_s_tvalid <= 1'b0;
                if (src_gap != 0)
                    src_gap--;
            end
        end else if (!i_s_tvalid) begin
            if (src_on && src_gap == 0 && stim_q.size() != 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= stim_q[0].ch;
                i_s_tlast  <= stim_q[0].last;
            end else if (src_gap != 0) begin
                src_gap--;
            end
        end
        // offered and not taken: hold the item as it is
    end

    // receiver: checks each item, stalls in bursts and once for a long stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_item = '{o_m_tdata, o_m_tuser, o_m_tlast};
            if (stripped_q.size() == 0) begin
                report_mismatch("item with nothing expected, tdata", got_item.ch, 0);
            end else begin
                want_item = stripped_q.pop_front();
                if (got_item.ch !== want_item.ch)
                    report_mismatch("out_char", got_item.ch, want_item.ch);
                if (got_item.has !== want_item.has)
                    report_mismatch("has_char", got_item.has, want_item.has);
                if (got_item.last !== want_item.last)
                    report_mismatch("out_last", got_item.last, want_item.last);
            end
            n_items_out++;
        end

        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!backlog_done && n_items_out >= BACKLOG_AT) begin
            // long hold so the internal queue fills and the input backs up
            backlog_done = 1'b1;
            hold_left = BACKLOG_HOLD - 1;
            i_m_tready <= 1'b0;
        end else if (stim_q.size() >= QUIET_TAIL && $urandom_range(0, 6) == 0) begin
            hold_left = $urandom_range(0, 4);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // watchdog: too long with no item moving on either side
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/jcs_pkg.sv
rtl/core/jcs_front.sv
rtl/core/jcs_queue.sv
rtl/core/jcs_back.sv
rtl/core/json_comment_stripper.sv
verif/json_comment_stripper_tb.sv
